[rtl/lcmn_pkg.sv]
// ----------------------------------------------------------------------------
// lcmn_pkg
// Shared types and constants of the live cepstral mean normalizer.
// ----------------------------------------------------------------------------
package lcmn_pkg;

    localparam logic [1:0] OP_NORM   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] REG_VLEN = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;
    localparam logic [1:0] REG_KEEP = 2'd2;

    localparam logic [15:0] MEAN0_RESET = 16'sd2048;
    localparam logic [12:0] COUNT_MAX   = 13'd8191;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RC_READ,
        ST_RC_WAIT,
        ST_DIV_MEAN,
        ST_MUL,
        ST_DIV_SUM,
        ST_RC_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [44:0] dividend;
        logic [12:0] divisor;
    } div_req_t;

endpackage

[rtl/lcmn_divider.sv]
// ----------------------------------------------------------------------------
// lcmn_divider
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module lcmn_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcmn_pkg::div_req_t req,
    output logic               done,
    output logic signed [44:0] quotient
);
    import lcmn_pkg::*;

    logic [44:0] quo_reg, quo_next;
    logic [12:0] rem_reg, rem_next;
    logic [12:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [13:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[44]} - {1'b0, dsr_reg};
        if (req.start) begin
            neg_next  = req.dividend[44];
            quo_next  = req.dividend[44] ? (~req.dividend + 45'd1) : req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'd45;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[13]) begin
                rem_next = trial[12:0];
                quo_next = {quo_reg[43:0], 1'b1};
            end else begin
                rem_next = {rem_reg[11:0], quo_reg[44]};
                quo_next = {quo_reg[43:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

[rtl/live_cepstral_mean_normalizer.sv]
// ----------------------------------------------------------------------------
// live_cepstral_mean_normalizer
// Sliding-window cepstral mean normalizer, Q8.8, means and sums in RAM.
// ----------------------------------------------------------------------------
// Usage: feed words on s_axis (operation, coef_index, coef_value); each word
// yields one result word on m_axis. Registers are written on the cfg channel
// (cfg_addr 0 vector_length, 1 window_high, 2 window_keep); the user must
// write them only while idle, the block itself does not enforce it. A plain
// normalize, load or read word passes the execute state and the output
// register before its result shows; the RAM read runs while the word is
// offered. A new word is taken only after the last result has been taken.
// A word that recomputes means walks the frame entries one at a time through
// the serial divider, with a second division for the decayed sum when the
// window shifts. After reset the block sweeps all MAX_COEFS entries of both
// RAMs to load their reset values and takes no word meanwhile. A stalled receiver
// holds the result word in the output register and the block takes no new word.
// ----------------------------------------------------------------------------
module live_cepstral_mean_normalizer #(
    parameter int MAX_COEFS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // operation[1:0], coef_index[5:2], coef_value[21:6]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_value[15:0], saturated[16],
                                       // window_shifted[17], frames_seen[30:18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_data
);
    import lcmn_pkg::*;

    localparam int AW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int LW = $clog2(MAX_COEFS + 1);

    logic signed [15:0] mean_mem [MAX_COEFS];
    logic signed [31:0] sum_mem  [MAX_COEFS];

    logic [4:0]  vlen_reg;
    logic [11:0] high_reg, keep_reg;
    logic [12:0] cnt_reg, cnt_next;
    state_t      st_reg, st_next;

    logic [1:0]  op_reg, op_next;
    logic [3:0]  idx_reg, idx_next;
    logic signed [15:0] val_reg, val_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic        shift_reg, shift_next;
    logic signed [44:0] prod_reg;
    logic signed [31:0] sumq_reg, sumq_next;

    logic signed [15:0] mean_rd;
    logic signed [31:0] sum_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          mean_we, sum_we;
    logic signed [15:0] mean_wd;
    logic signed [31:0] sum_wd;

    logic [15:0] res_reg, res_next;
    logic        sat_reg, sat_next, shf_reg, shf_next;
    logic        mv_reg, mv_next;

    div_req_t    dreq;
    logic        ddone;
    logic signed [44:0] dq;

    lcmn_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone),
                        .quotient(dq));

    logic [LW-1:0] n_eff;
    always_comb begin
        if (vlen_reg == 5'd0) n_eff = LW'(1);
        else if (32'(vlen_reg) > MAX_COEFS) n_eff = LW'(MAX_COEFS);
        else n_eff = LW'(vlen_reg);
    end

    logic in_frame;
    assign in_frame = (32'(idx_reg) < 32'(n_eff));

    always_ff @(posedge aclk) begin
        if (mean_we) mean_mem[wr_addr] <= mean_wd;
        if (sum_we)  sum_mem[wr_addr]  <= sum_wd;
        mean_rd <= mean_mem[rd_addr];
        sum_rd  <= sum_mem[rd_addr];
    end

    logic signed [32:0] sadd;
    logic signed [16:0] sdiff;
    logic signed [44:0] mq;
    logic signed [44:0] lprod;

    always_comb begin
        st_next    = st_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        ptr_next   = ptr_reg;
        shift_next = shift_reg;
        sumq_next  = sumq_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        sat_next   = sat_reg;
        shf_next   = shf_reg;
        mv_next    = mv_reg;
        rd_addr    = ptr_reg;
        wr_addr    = ptr_reg;
        mean_we    = 1'b0;
        sum_we     = 1'b0;
        mean_wd    = '0;
        sum_wd     = '0;
        dreq       = '0;
        s_axis_tready = 1'b0;
        sadd  = 33'(sum_rd) + 33'(val_reg);
        sdiff = 17'(val_reg) - 17'(mean_rd);
        mq    = dq;
        lprod = 45'(val_reg) * $signed({33'd0, keep_reg});

        if (mv_reg && m_axis_tready) mv_next = 1'b0;

        case (st_reg)
            ST_CLEAR: begin
                wr_addr = ptr_reg;
                mean_we = 1'b1;
                sum_we  = 1'b1;
                mean_wd = (ptr_reg == '0) ? MEAN0_RESET : 16'sd0;
                if (32'(ptr_reg) == MAX_COEFS - 1) st_next = ST_IDLE;
                else ptr_next = ptr_reg + AW'(1);
            end
            ST_IDLE: begin
                s_axis_tready = !mv_reg;
                rd_addr = AW'(s_axis_tdata[5:2]);
                if (s_axis_tvalid && !mv_reg) begin
                    op_next  = s_axis_tdata[1:0];
                    idx_next = s_axis_tdata[5:2];
                    val_next = s_axis_tdata[21:6];
                    st_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next = '0;
                sat_next = 1'b0;
                shf_next = 1'b0;
                wr_addr  = AW'(idx_reg);
                st_next  = ST_OUT;
                if (op_reg == OP_UPDATE) begin
                    if (cnt_reg != '0) begin
                        shift_next = (cnt_reg > {1'b0, high_reg});
                        ptr_next = '0;
                        st_next  = ST_RC_READ;
                    end
                end else if (in_frame) begin
                    case (op_reg)
                        OP_NORM: begin
                            sum_we = 1'b1;
                            if (sadd > 33'sh0_7FFF_FFFF) sum_wd = 32'sh7FFF_FFFF;
                            else if (sadd < -33'sh0_8000_0000) sum_wd = 32'sh8000_0000;
                            else sum_wd = sadd[31:0];
                            if (sdiff > 17'sd32767) begin
                                res_next = 16'h7FFF; sat_next = 1'b1;
                            end else if (sdiff < -17'sd32768) begin
                                res_next = 16'h8000; sat_next = 1'b1;
                            end else res_next = sdiff[15:0];
                            if (32'(idx_reg) == 32'(n_eff) - 1) begin
                                cnt_next = (cnt_reg < COUNT_MAX) ? cnt_reg + 13'd1 : cnt_reg;
                                if (cnt_next > {1'b0, high_reg}) begin
                                    shift_next = 1'b1;
                                    ptr_next = '0;
                                    st_next  = ST_RC_READ;
                                end
                            end
                        end
                        OP_LOAD: begin
                            mean_we = 1'b1;
                            sum_we  = 1'b1;
                            mean_wd = val_reg;
                            sum_wd  = lprod[31:0];
                            cnt_next = {1'b0, keep_reg};
                        end
                        OP_READ: res_next = mean_rd;
                        default: ;
                    endcase
                end
            end
            ST_RC_READ: begin
                rd_addr = ptr_reg;
                st_next = ST_RC_WAIT;
            end
            ST_RC_WAIT: begin
                dreq.start    = 1'b1;
                dreq.dividend = 45'(sum_rd);
                dreq.divisor  = cnt_reg;
                st_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                if (ddone) begin
                    wr_addr = ptr_reg;
                    mean_we = 1'b1;
                    if (mq > 45'sd32767) mean_wd = 16'sh7FFF;
                    else if (mq < -45'sd32768) mean_wd = 16'sh8000;
                    else mean_wd = mq[15:0];
                    st_next = shift_reg ? ST_MUL : ST_RC_WRITE;
                end
            end
            ST_MUL: begin
                dreq.start    = 1'b1;
                dreq.dividend = prod_reg;
                dreq.divisor  = cnt_reg;
                st_next = ST_DIV_SUM;
            end
            ST_DIV_SUM: begin
                if (ddone) begin
                    if (mq > 45'sh7FFF_FFFF) sumq_next = 32'sh7FFF_FFFF;
                    else if (mq < -45'sh8000_0000) sumq_next = 32'sh8000_0000;
                    else sumq_next = mq[31:0];
                    st_next = ST_RC_WRITE;
                end
            end
            ST_RC_WRITE: begin
                wr_addr = ptr_reg;
                sum_we  = shift_reg;
                sum_wd  = sumq_reg;
                if (32'(ptr_reg) == 32'(n_eff) - 1) begin
                    if (shift_reg) cnt_next = {1'b0, keep_reg};
                    shf_next = shift_reg;
                    st_next  = ST_OUT;
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                    st_next  = ST_RC_READ;
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_CLEAR;
            ptr_reg  <= '0;
            cnt_reg  <= '0;
            mv_reg   <= 1'b0;
            vlen_reg <= 5'd13;
            high_reg <= 12'd800;
            keep_reg <= 12'd500;
        end else begin
            st_reg  <= st_next;
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
            mv_reg  <= mv_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_VLEN: vlen_reg <= cfg_data[4:0];
                    REG_HIGH: high_reg <= cfg_data;
                    REG_KEEP: keep_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        shift_reg <= shift_next;
        sumq_reg  <= sumq_next;
        res_reg   <= res_next;
        sat_reg   <= sat_next;
        shf_reg   <= shf_next;
        prod_reg  <= 45'(sum_rd) * $signed({33'd0, keep_reg});
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {1'b0, cnt_reg, shf_reg, sat_reg, res_reg};

endmodule

[tb/sv/live_cepstral_mean_normalizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// live_cepstral_mean_normalizer_tb
// Self-checking bench: drives coefficient words with random idling on both
// stream sides, predicts each result from its own copy of means, sums and
// frame count, and compares every result word field by field.
// ----------------------------------------------------------------------------
module live_cepstral_mean_normalizer_tb;
    import lcmn_pkg::*;

    typedef struct packed {
        logic [15:0] val;
        logic [3:0]  idx;
        logic [1:0]  op;
    } coef_word_t;

    typedef struct packed {
        logic [12:0] frames;
        logic        shifted;
        logic        sat;
        logic [15:0] value;
    } norm_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [11:0] cfg_data = '0;

    live_cepstral_mean_normalizer u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    coef_word_t   pending_words[$];
    norm_result_t expected_results[$];
    int           errors = 0;
    int           accepted = 0;
    int           checked = 0;
    int           shifts_seen = 0;
    int           cycles = 0;
    bit           quiet = 1'b0;

    // predictor state
    logic [4:0]         p_vlen;
    logic [11:0]        p_high, p_keep;
    logic signed [15:0] p_mean[16];
    logic signed [31:0] p_sum[16];
    logic [12:0]        p_count;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int eff_len();
        if (p_vlen == 0) return 1;
        if (p_vlen > 16) return 16;
        return p_vlen;
    endfunction

    function automatic bit refresh_means();
        longint cnt, q;
        int n;
        cnt = p_count;
        n = eff_len();
        if (cnt == 0) return 0;
        for (int i = 0; i < n; i++) begin
            q = longint'(p_sum[i]) / cnt;
            p_mean[i] = (q > 32767) ? 16'sh7fff : (q < -32768) ? 16'sh8000 : q[15:0];
        end
        if (p_count > p_high) begin
            for (int i = 0; i < n; i++)
                p_sum[i] = clamp32((longint'(p_sum[i]) * longint'(p_keep)) / cnt);
            p_count = {1'b0, p_keep};
            return 1;
        end
        return 0;
    endfunction

    function automatic norm_result_t predict_norm(coef_word_t w);
        norm_result_t r;
        longint d;
        int n;
        n = eff_len();
        r = '0;
        if (w.op == OP_UPDATE) begin
            r.shifted = refresh_means();
        end else if (w.idx < n) begin
            if (w.op == OP_NORM) begin
                p_sum[w.idx] = clamp32(longint'(p_sum[w.idx]) + longint'($signed(w.val)));
                d = longint'($signed(w.val)) - longint'(p_mean[w.idx]);
                if (d > 32767) begin
                    r.value = 16'h7fff; r.sat = 1;
                end else if (d < -32768) begin
                    r.value = 16'h8000; r.sat = 1;
                end else begin
                    r.value = d[15:0];
                end
                if (w.idx == n - 1) begin
                    if (p_count < COUNT_MAX) p_count++;
                    if (p_count > p_high) r.shifted = refresh_means();
                end
            end else if (w.op == OP_LOAD) begin
                p_mean[w.idx] = w.val;
                p_sum[w.idx] = clamp32(longint'($signed(w.val)) * longint'(p_keep));
                p_count = {1'b0, p_keep};
            end else begin
                r.value = p_mean[w.idx];
            end
        end
        r.frames = p_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        coef_word_t w;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                w = s_axis_tdata[21:0];
                expected_results.push_back(predict_norm(w));
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_axis_tdata  <= {2'b00, pending_words.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(3) == 0) s_gap = $urandom_range(1, 3);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        norm_result_t got, want;
        cycles++;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[30:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", got, 0);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.shifted) shifts_seen++;
                    if (got.value != want.value)
                        report_mismatch("result_value", $signed(got.value), $signed(want.value));
                    if (got.sat != want.sat) report_mismatch("saturated", got.sat, want.sat);
                    if (got.shifted != want.shifted)
                        report_mismatch("window_shifted", got.shifted, want.shifted);
                    if (got.frames != want.frames)
                        report_mismatch("frames_seen", got.frames, want.frames);
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(3) == 0) m_gap = $urandom_range(1, 3);
            end
        end
        if (cycles > 10000000) begin
            $display("live_cepstral_mean_normalizer_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] a, logic [11:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (a == REG_VLEN) p_vlen = d[4:0];
        else if (a == REG_HIGH) p_high = d;
        else p_keep = d;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic coef_word_t make_word(logic [1:0] op, logic [3:0] idx, logic [15:0] v);
        coef_word_t w;
        w.op = op; w.idx = idx; w.val = v;
        return w;
    endfunction

    // well-formed frames with occasional other operations
    task automatic queue_frames(int frames, int vlen);
        for (int f = 0; f < frames; f++) begin
            for (int i = 0; i < vlen; i++) begin
                if ($urandom_range(15) == 0)
                    pending_words.push_back(make_word(2'($urandom_range(3)),
                                                      4'($urandom_range(15)), 16'($urandom)));
                else
                    pending_words.push_back(make_word(OP_NORM, 4'(i),
                        ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095))));
            end
        end
    endtask

    initial begin
        p_vlen = 13; p_high = 800; p_keep = 500; p_count = 0;
        foreach (p_mean[i]) begin
            p_mean[i] = 0; p_sum[i] = 0;
        end
        p_mean[0] = MEAN0_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset means, extremes, ignored positions, update at zero
        pending_words.push_back(make_word(OP_READ, 0, 0));
        pending_words.push_back(make_word(OP_UPDATE, 0, 0));
        pending_words.push_back(make_word(OP_NORM, 0, 16'h8000));
        pending_words.push_back(make_word(OP_NORM, 1, 16'h7fff));
        pending_words.push_back(make_word(OP_NORM, 15, 16'h1234));
        pending_words.push_back(make_word(OP_READ, 14, 0));
        pending_words.push_back(make_word(OP_LOAD, 1, 16'h8000));
        pending_words.push_back(make_word(OP_NORM, 1, 16'h7fff));
        pending_words.push_back(make_word(OP_LOAD, 2, 16'h7fff));
        pending_words.push_back(make_word(OP_NORM, 2, 16'h8000));
        pending_words.push_back(make_word(OP_LOAD, 13, 16'h0100));
        pending_words.push_back(make_word(OP_UPDATE, 5, 0));
        pending_words.push_back(make_word(OP_READ, 1, 0));
        pending_words.push_back(make_word(OP_READ, 12, 0));
        drain();

        // tiny window so shifts come often
        write_reg(REG_VLEN, 2);
        write_reg(REG_HIGH, 3);
        write_reg(REG_KEEP, 1);
        for (int i = 0; i < 2; i++) pending_words.push_back(make_word(OP_LOAD, 4'(i), 16'hf000));
        queue_frames(60, 2);
        pending_words.push_back(make_word(OP_UPDATE, 0, 0));
        drain();

        // odd settings: length 0 and keep above high
        write_reg(REG_VLEN, 0);
        write_reg(REG_HIGH, 2);
        write_reg(REG_KEEP, 4094);
        queue_frames(20, 1);
        drain();
        write_reg(REG_KEEP, 0);
        queue_frames(20, 2);
        pending_words.push_back(make_word(OP_UPDATE, 0, 0));
        drain();

        // full width, above MAX_COEFS
        write_reg(REG_VLEN, 31);
        write_reg(REG_HIGH, 4);
        write_reg(REG_KEEP, 2);
        queue_frames(12, 16);
        drain();

        write_reg(REG_VLEN, 16);
        write_reg(REG_HIGH, 4095);
        write_reg(REG_KEEP, 1);
        queue_frames(10, 16);
        pending_words.push_back(make_word(OP_UPDATE, 0, 0));
        drain();

        write_reg(REG_VLEN, 4);
        write_reg(REG_HIGH, 6);
        write_reg(REG_KEEP, 3);
        queue_frames(100, 4);
        drain();

        // noise and tail without idling
        write_reg(REG_VLEN, 3);
        for (int i = 0; i < 200; i++)
            pending_words.push_back(make_word(2'($urandom_range(3)), 4'($urandom_range(15)),
                                              16'($urandom)));
        drain();
        quiet = 1'b1;
        queue_frames(100, 3);
        drain();

        $display("covered %0d words, %0d results checked, %0d window shifts",
                 accepted, checked, shifts_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("live_cepstral_mean_normalizer_tb: PASS");
        else
            $display("live_cepstral_mean_normalizer_tb: FAIL");
        $finish;
    end
endmodule

[filelist.f]
rtl/lcmn_pkg.sv
rtl/lcmn_divider.sv
rtl/live_cepstral_mean_normalizer.sv
tb/sv/live_cepstral_mean_normalizer_tb.sv
